FILE: src/alpe_pkg.sv
// ----------------------------------------------------------------------------
// alpe_pkg
// Shared codes and constants for the addressable LED pulse encoder.
// ----------------------------------------------------------------------------
package alpe_pkg;

  // Request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_SEND  = 2'd2;
  localparam logic [1:0] KIND_ZEROS = 2'd3;

  // Pulse phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  // Timing register indexes
  localparam logic [1:0] REG_ONE_HIGH  = 2'd0;
  localparam logic [1:0] REG_ONE_LOW   = 2'd1;
  localparam logic [1:0] REG_ZERO_HIGH = 2'd2;
  localparam logic [1:0] REG_ZERO_LOW  = 2'd3;

  // Timing register reset values
  localparam logic [7:0] RST_ONE_HIGH  = 8'd30;
  localparam logic [7:0] RST_ONE_LOW   = 8'd26;
  localparam logic [7:0] RST_ZERO_HIGH = 8'd11;
  localparam logic [7:0] RST_ZERO_LOW  = 8'd43;

  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned PosW         = 5;

  typedef logic [BITS_PER_LED-1:0] colour_t;

endpackage

FILE: src/alpe_ram.sv
// ----------------------------------------------------------------------------
// alpe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module alpe_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 3,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/addressable_led_pulse_encoder.sv
// ----------------------------------------------------------------------------
// addressable_led_pulse_encoder
// One-wire pulse encoder for a chain of addressable RGB LEDs.
// ----------------------------------------------------------------------------
// Every request (tick, set colour, send, send zeros) gives one response, and
// requests may arrive on every cycle while the response register is free or
// being drained; the response register frees itself in the cycle it is taken.
// Colours live in a RAM of LED_COUNT 24-bit entries (green, red, blue) with a
// registered read port: the entry for LED 0 is read when a send starts and the
// next entry is read at each LED boundary, and the fresh read data is forwarded
// straight into the bit selection, so no tick waits. Per-entry valid flags make
// the store read as zero after reset without a clearing pass. Timing registers
// are read live; a zero length acts as one tick.
module addressable_led_pulse_encoder #(
  parameter int unsigned LED_COUNT = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Timing register write port
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  // Request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] pixel_idx_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  // Response channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       pin_level_o,
  output logic       busy_res_o,
  output logic       rejected_o
);
  import alpe_pkg::*;

  localparam int unsigned LedW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  // Timing registers
  logic [7:0] cfg_q [4];

  // Frame state
  logic [1:0]      phase_q, phase_d;
  logic [7:0]      ticks_q, ticks_d;
  logic [LedW-1:0] led_q, led_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            zeros_q, zeros_d;
  colour_t         word_q, word_d;
  logic            rd_pend_q;
  logic            rd_vld_q;
  logic [LED_COUNT-1:0] vld_q;

  // Response register
  logic out_valid_q, out_valid_d;
  logic pin_q, pin_d;
  logic busy_q, busy_d;
  logic rej_q, rej_d;

  // RAM access
  logic            ram_we;
  logic            ram_re;
  logic [LedW-1:0] ram_waddr;
  logic [LedW-1:0] ram_raddr;
  colour_t         ram_wdata;
  colour_t         ram_rdata;

  logic            acc;
  logic            busy;
  logic            in_range;
  colour_t         word_cur;
  logic            cur_bit;
  logic [1:0]      len_sel;
  logic [7:0]      len;
  logic [7:0]      ticks_inc;
  logic            ph_done;
  logic            last_bit;
  logic            last_led;
  logic [LedW-1:0] led_next;

  alpe_ram #(
    .Width(BITS_PER_LED),
    .Depth(LED_COUNT),
    .AddrW(LedW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Take a request whenever the response register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign busy       = (phase_q != PH_IDLE);
  assign in_range   = ({1'b0, pixel_idx_i} < 9'(LED_COUNT));

  // Forward fresh read data; an unwritten entry reads as zero
  assign word_cur = rd_pend_q ? (rd_vld_q ? ram_rdata : '0) : word_q;
  assign cur_bit  = !zeros_q && word_cur[BITS_PER_LED-1];

  // Phase length from the live timing registers
  always_comb begin
    if (phase_q == PH_HIGH) begin
      len_sel = cur_bit ? REG_ONE_HIGH : REG_ZERO_HIGH;
    end else begin
      len_sel = cur_bit ? REG_ONE_LOW : REG_ZERO_LOW;
    end
  end

  assign len       = (cfg_q[len_sel] == 8'd0) ? 8'd1 : cfg_q[len_sel];
  assign ticks_inc = ticks_q + 8'd1;
  assign ph_done   = (ticks_inc == 8'd0) || (ticks_inc >= len);
  assign last_bit  = (pos_q == PosW'(BITS_PER_LED - 1));
  assign last_led  = (led_q == LedW'(LED_COUNT - 1));
  assign led_next  = led_q + LedW'(1);

  assign ram_waddr = pixel_idx_i[LedW-1:0];
  assign ram_wdata = {green_i, red_i, blue_i};

  // Advance the frame and build the response
  always_comb begin
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    led_d     = led_q;
    pos_d     = pos_q;
    zeros_d   = zeros_q;
    word_d    = word_cur;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = led_next;
    pin_d     = pin_q;
    busy_d    = busy_q;
    rej_d     = rej_q;

    if (acc) begin
      pin_d = (phase_q == PH_HIGH);
      rej_d = 1'b0;
      case (kind_i)
        KIND_TICK: begin
          if (busy) begin
            ticks_d = ticks_inc;
            if (ph_done) begin
              ticks_d = 8'd0;
              if (phase_q == PH_HIGH) begin
                phase_d = PH_LOW;
              end else begin
                word_d  = word_cur << 1;
                phase_d = PH_HIGH;
                if (last_bit) begin
                  pos_d = '0;
                  if (last_led) begin
                    phase_d = PH_IDLE;
                    led_d   = '0;
                    zeros_d = 1'b0;
                  end else begin
                    led_d  = led_next;
                    ram_re = 1'b1;
                  end
                end else begin
                  pos_d = pos_q + PosW'(1);
                end
              end
            end
          end
        end
        KIND_SET: begin
          if (busy || !in_range) begin
            rej_d = 1'b1;
          end else begin
            ram_we = 1'b1;
          end
        end
        default: begin
          if (busy) begin
            rej_d = 1'b1;
          end else begin
            zeros_d   = (kind_i == KIND_ZEROS);
            pos_d     = '0;
            led_d     = '0;
            ticks_d   = 8'd0;
            phase_d   = PH_HIGH;
            ram_re    = 1'b1;
            ram_raddr = '0;
          end
        end
      endcase
      busy_d = (kind_i == KIND_TICK) ? busy : (phase_d != PH_IDLE);
    end
  end

  // Hold the response until taken
  assign out_valid_d = acc || (out_valid_q && !out_ready_i);

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_ONE_HIGH]  <= RST_ONE_HIGH;
      cfg_q[REG_ONE_LOW]   <= RST_ONE_LOW;
      cfg_q[REG_ZERO_HIGH] <= RST_ZERO_HIGH;
      cfg_q[REG_ZERO_LOW]  <= RST_ZERO_LOW;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ticks_q     <= '0;
      led_q       <= '0;
      pos_q       <= '0;
      zeros_q     <= 1'b0;
      rd_pend_q   <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      ticks_q     <= ticks_d;
      led_q       <= led_d;
      pos_q       <= pos_d;
      zeros_q     <= zeros_d;
      rd_pend_q   <= ram_re;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    pin_q  <= pin_d;
    busy_q <= busy_d;
    rej_q  <= rej_d;
    if (ram_re) begin
      rd_vld_q <= vld_q[ram_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign pin_level_o = pin_q;
  assign busy_res_o  = busy_q;
  assign rejected_o  = rej_q;

endmodule

FILE: src/alpe_checker.sv
// ----------------------------------------------------------------------------
// alpe_checker
// Port-level checks for the addressable LED pulse encoder.
// ----------------------------------------------------------------------------
module alpe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [1:0] cfg_idx_i,
  input logic [7:0] cfg_data_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] kind_i,
  input logic [7:0] pixel_idx_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       pin_level_o,
  input logic       busy_res_o,
  input logic       rejected_o
);

  // Hold a stalled response
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pin_level_o)
      && $stable(busy_res_o) && $stable(rejected_o))
    else $error("stalled response changed");

  // Every accepted request gives a response in the next cycle
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request gave no response");

  // An empty response register never blocks requests
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("ready low with empty response register");

  // A high wire only occurs inside a frame
  a_pin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pin_level_o |-> busy_res_o)
    else $error("pin high outside a frame");

endmodule

bind addressable_led_pulse_encoder alpe_checker u_alpe_checker (.*);

FILE: test/addressable_led_pulse_encoder_test.sv
// ----------------------------------------------------------------------------
// addressable_led_pulse_encoder_test
// Self-checking bench for the one-wire LED pulse encoder. A short table of
// requests covers reset state, store extremes, out-of-range indexes and
// commands while a frame is running; random traffic then builds colour
// frames, sends them and ticks them out under several timing settings and
// handshake idling patterns. Every response is checked against its typed table
// value if any, else an in-bench model of the colour store and pulse sequencer.
// ----------------------------------------------------------------------------
module addressable_led_pulse_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import alpe_pkg::*;

  localparam int unsigned LEDS = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pixel_idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } request_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic rejected;
  } response_t;

  typedef struct {
    request_t  rq;
    bit        typed;
    response_t want;
  } dir_row_t;

  typedef struct {
    logic [7:0] one_high;
    logic [7:0] one_low;
    logic [7:0] zero_high;
    logic [7:0] zero_low;
    int         sender_pct;
    int         recv_pct;
    int         count;
    int         hold;
  } phase_t;

  // DUT ports
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = '0;
  logic [7:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [1:0] kind_i      = '0;
  logic [7:0] pixel_idx_i = '0;
  logic [7:0] red_i       = '0;
  logic [7:0] green_i     = '0;
  logic [7:0] blue_i      = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       pin_level_o;
  logic       busy_res_o;
  logic       rejected_o;

  // Model of the encoder state
  colour_t    led_colour [LEDS];
  int         frame_bit;
  logic [1:0] pulse_state;
  logic [7:0] pulse_count;
  logic       zeros_frame;
  logic [7:0] timing [4];

  response_t  owed_responses [$];
  bit         typed_want_on = 1'b0;
  response_t  typed_want    = '0;
  int         fail_count    = 0;
  int         sender_pct    = 0;
  int         recv_pct      = 0;
  int         hold_ask      = 0;
  int         hold_left     = 0;

  // Directed requests with reset timing; typed responses where obvious
  dir_row_t directed_rows [15] = '{
    '{'{KIND_TICK,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{KIND_SET,   8'h00, 8'h00, 8'hff, 8'hff}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{KIND_SET,   8'h01, 8'hff, 8'h00, 8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{KIND_SET,   8'h02, 8'h5a, 8'ha5, 8'hc3}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{KIND_SET,   8'h03, 8'hff, 8'hff, 8'hff}, 1'b1, '{1'b0, 1'b0, 1'b1}},
    '{'{KIND_SET,   8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 1'b0, 1'b1}},
    '{'{KIND_TICK,  8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{KIND_SEND,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 1'b1, 1'b0}},
    '{'{KIND_TICK,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b1, 1'b1, 1'b0}},
    '{'{KIND_SET,   8'h00, 8'h12, 8'h34, 8'h56}, 1'b1, '{1'b1, 1'b1, 1'b1}},
    '{'{KIND_ZEROS, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b1, 1'b1, 1'b1}},
    '{'{KIND_SEND,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b1, 1'b1, 1'b1}},
    '{'{KIND_TICK,  8'h80, 8'h01, 8'h02, 8'h04}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  8'h7f, 8'hfe, 8'hfd, 8'hfb}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0, 1'b0}}
  };

  // Timing settings and idling pattern of each random phase
  phase_t phases [6] = '{
    '{8'd1,   8'd1,   8'd1,   8'd1,   0,  0,  300, 60},
    '{8'd0,   8'd0,   8'd0,   8'd0,   80, 0,  200, 0},
    '{8'd2,   8'd1,   8'd1,   8'd2,   0,  80, 250, 0},
    '{8'd255, 8'd255, 8'd255, 8'd255, 19, 19, 550, 0},
    '{8'd3,   8'd1,   8'd2,   8'd1,   0,  0,  300, 0},
    '{8'd1,   8'd4,   8'd4,   8'd1,   19, 19, 120, 0}
  };

  addressable_led_pulse_encoder #(
    .LED_COUNT(LEDS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .pixel_idx_i (pixel_idx_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pin_level_o (pin_level_o),
    .busy_res_o  (busy_res_o),
    .rejected_o  (rejected_o)
  );

  always #10 clk_i = ~clk_i;

  // Length of the current pulse; a zero register counts as one tick
  function automatic logic [7:0] pulse_len();
    logic       one;
    logic [1:0] sel;
    one = zeros_frame ? 1'b0 :
          led_colour[frame_bit / BITS_PER_LED][BITS_PER_LED - 1 - frame_bit % BITS_PER_LED];
    if (pulse_state == PH_HIGH) begin
      sel = one ? REG_ONE_HIGH : REG_ZERO_HIGH;
    end else begin
      sel = one ? REG_ONE_LOW : REG_ZERO_LOW;
    end
    return (timing[sel] == 8'd0) ? 8'd1 : timing[sel];
  endfunction

  // Advance the encoder model by one request and give its response
  task automatic encode_step(input request_t rq, output response_t rs);
    logic       busy;
    logic [7:0] len;
    busy         = (pulse_state != PH_IDLE);
    rs.pin_level = (pulse_state == PH_HIGH);
    rs.rejected  = 1'b0;
    if (rq.kind == KIND_TICK) begin
      rs.busy_res = busy;
      if (busy) begin
        len         = pulse_len();
        pulse_count = pulse_count + 8'd1;
        if (pulse_count == 8'd0 || pulse_count >= len) begin
          pulse_count = 8'd0;
          if (pulse_state == PH_HIGH) begin
            pulse_state = PH_LOW;
          end else begin
            frame_bit++;
            if (frame_bit >= LEDS * BITS_PER_LED) begin
              // last low pulse done: frame over
              frame_bit   = 0;
              pulse_state = PH_IDLE;
              zeros_frame = 1'b0;
            end else begin
              pulse_state = PH_HIGH;
            end
          end
        end
      end
    end else begin
      if (busy) begin
        rs.rejected = 1'b1;
      end else if (rq.kind == KIND_SET) begin
        if (rq.pixel_idx < LEDS) begin
          led_colour[rq.pixel_idx] = {rq.green, rq.red, rq.blue};
        end else begin
          rs.rejected = 1'b1;
        end
      end else begin
        zeros_frame = (rq.kind == KIND_ZEROS);
        frame_bit   = 0;
        pulse_count = 8'd0;
        pulse_state = PH_HIGH;
      end
      rs.busy_res = (pulse_state != PH_IDLE);
    end
  endtask

  // Mostly well-formed traffic: fill the store and send when idle, tick when busy
  function automatic request_t pick_request();
    request_t rq;
    int       roll;
    rq.kind      = KIND_TICK;
    rq.pixel_idx = 8'($urandom);
    rq.red       = 8'($urandom);
    rq.green     = 8'($urandom);
    rq.blue      = 8'($urandom);
    roll         = $urandom_range(99);
    if (pulse_state != PH_IDLE) begin
      if (roll < 4) rq.kind = 2'($urandom_range(3, 1));
    end else if (roll < 45) begin
      rq.kind      = KIND_SET;
      rq.pixel_idx = (roll < 40) ? 8'($urandom_range(LEDS - 1)) : 8'($urandom_range(255, LEDS));
    end else if (roll < 65) begin
      rq.kind = KIND_SEND;
    end else if (roll < 75) begin
      rq.kind = KIND_ZEROS;
    end
    return rq;
  endfunction

  // Offer one request and hold it until taken; called at a falling edge
  task automatic issue(input request_t rq, input bit typed, input response_t want);
    while (sender_pct != 0 && $urandom_range(99) < sender_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= rq.kind;
    pixel_idx_i   <= rq.pixel_idx;
    red_i         <= rq.red;
    green_i       <= rq.green;
    blue_i        <= rq.blue;
    typed_want_on = typed;
    typed_want    = want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every owed response is back
  task automatic await_quiet();
    in_valid_i <= 1'b0;
    while (owed_responses.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write all four pulse length registers
  task automatic program_timing(input logic [7:0] oh, input logic [7:0] ol,
                                input logic [7:0] zh, input logic [7:0] zl);
    logic [7:0] vals [4];
    vals[REG_ONE_HIGH]  = oh;
    vals[REG_ONE_LOW]   = ol;
    vals[REG_ZERO_HIGH] = zh;
    vals[REG_ZERO_LOW]  = zl;
    for (int r = 0; r < 4; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(r);
      cfg_data_i <= vals[r];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_pct);
    end
  end

  // Predict on each accepted request, check each accepted response
  always @(posedge clk_i) begin
    request_t  rq;
    response_t rs;
    response_t got;
    response_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        rq = '{kind_i, pixel_idx_i, red_i, green_i, blue_i};
        encode_step(rq, rs);
        owed_responses.push_back(typed_want_on ? typed_want : rs);
      end
      if (out_valid_o && out_ready_i) begin
        got = '{pin_level_o, busy_res_o, rejected_o};
        if (owed_responses.size() == 0) begin
          $display("%0t: response with none owed: pin %0b busy %0b rejected %0b",
                   $time, got.pin_level, got.busy_res, got.rejected);
          fail_count++;
        end else begin
          want = owed_responses.pop_front();
          if (got.pin_level !== want.pin_level) begin
            $display("%0t: pin_level expected %0b got %0b", $time, want.pin_level, got.pin_level);
            fail_count++;
          end
          if (got.busy_res !== want.busy_res) begin
            $display("%0t: busy_res expected %0b got %0b", $time, want.busy_res, got.busy_res);
            fail_count++;
          end
          if (got.rejected !== want.rejected) begin
            $display("%0t: rejected expected %0b got %0b", $time, want.rejected, got.rejected);
            fail_count++;
          end
        end
      end
      if (cfg_we_i) timing[cfg_idx_i] = cfg_data_i;
    end
  end

  // Stimulus
  initial begin
    for (int i = 0; i < LEDS; i++) led_colour[i] = '0;
    frame_bit                = 0;
    pulse_state              = PH_IDLE;
    pulse_count              = 8'd0;
    zeros_frame              = 1'b0;
    timing[REG_ONE_HIGH]     = RST_ONE_HIGH;
    timing[REG_ONE_LOW]      = RST_ONE_LOW;
    timing[REG_ZERO_HIGH]    = RST_ZERO_HIGH;
    timing[REG_ZERO_LOW]     = RST_ZERO_LOW;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table, reset timing
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
    end
    await_quiet();

    // random phases; timing changes land while a frame may still be running
    foreach (phases[p]) begin
      program_timing(phases[p].one_high, phases[p].one_low,
                     phases[p].zero_high, phases[p].zero_low);
      sender_pct = phases[p].sender_pct;
      recv_pct   = phases[p].recv_pct;
      hold_ask   = phases[p].hold;
      for (int n = 0; n < phases[p].count; n++) begin
        if (n == phases[p].count / 2) await_quiet();
        issue(pick_request(), 1'b0, '0);
      end
      await_quiet();
    end

    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[addressable_led_pulse_encoder] OK");
    end else begin
      $display("[addressable_led_pulse_encoder] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[addressable_led_pulse_encoder] ERROR");
    $finish;
  end

endmodule
